>>> rtl/lkf_pkg.sv
package lkf_pkg;

  localparam int STATE_DIM_DEF = 4;
  localparam int MEAS_DIM_DEF  = 2;
  localparam int FRAC_BITS_DEF = 16;

  // item function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_PREDICT = 2'd1;
  localparam logic [1:0] FUNC_UPDATE  = 2'd2;

  // load targets
  localparam logic [2:0] SEL_EST    = 3'd0;
  localparam logic [2:0] SEL_COV    = 3'd1;
  localparam logic [2:0] SEL_TRANS  = 3'd2;
  localparam logic [2:0] SEL_MEAS   = 3'd3;
  localparam logic [2:0] SEL_MNOISE = 3'd4;
  localparam logic [2:0] SEL_PNOISE = 3'd5;

  // engine operations
  typedef enum logic [2:0] {
    OP_MAT,
    OP_ADD,
    OP_SUB,
    OP_IDSUB,
    OP_COPY,
    OP_DET,
    OP_DET1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;
    logic last;
    logic neg;
    logic diag;
  } tag_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ZWR,
    ST_JOB,
    ST_DRAIN,
    ST_DET,
    ST_DET_WAIT,
    ST_INV_RD,
    ST_INV_LD,
    ST_INV_DIV,
    ST_INV_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

>>> rtl/linear_kalman_filter.sv
// Linear Kalman filter, signed fixed point, one shared multiply-accumulate engine.
// A load beat gives no result. Predict and update run their job programs on the engine,
// then report the estimate one element at a time; update inverts S with the
// bit-per-cycle divider.
// One item in flight; the multiplier and the 2-read/1-write scratch memory set the pace.
// Reset: memory is swept to zero, one word per cycle (DEPTH words, 142 by default).
module linear_kalman_filter #(
  parameter int STATE_DIM = lkf_pkg::STATE_DIM_DEF,
  parameter int MEAS_DIM  = lkf_pkg::MEAS_DIM_DEF,
  parameter int FRAC_BITS = lkf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [2:0]         matrix_select,
  input  logic [2:0]         row_index,
  input  logic [2:0]         col_index,
  input  logic signed [31:0] load_value,
  input  logic signed [31:0] meas_first,
  input  logic signed [31:0] meas_second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         elem_index,
  output logic signed [31:0] elem_value,
  output logic               last_elem,
  output logic               status
);

  localparam int N  = STATE_DIM;
  localparam int M  = MEAS_DIM;
  localparam int NN = N * N;
  localparam int MN = M * N;
  localparam int MM = M * M;

  // scratch memory map
  localparam int OFS_X   = 0;
  localparam int OFS_P   = OFS_X + N;
  localparam int OFS_F   = OFS_P + NN;
  localparam int OFS_H   = OFS_F + NN;
  localparam int OFS_R   = OFS_H + MN;
  localparam int OFS_Q   = OFS_R + MM;
  localparam int OFS_Z   = OFS_Q + NN;
  localparam int OFS_FX  = OFS_Z + 2;
  localparam int OFS_HX  = OFS_FX + N;
  localparam int OFS_Y   = OFS_HX + M;
  localparam int OFS_HP  = OFS_Y + M;
  localparam int OFS_S   = OFS_HP + MN;
  localparam int OFS_SI  = OFS_S + MM;
  localparam int OFS_PHT = OFS_SI + MM;
  localparam int OFS_KG  = OFS_PHT + MN;
  localparam int OFS_KY  = OFS_KG + MN;
  localparam int OFS_TA  = OFS_KY + N;
  localparam int OFS_TB  = OFS_TA + NN;
  localparam int DEPTH   = OFS_TB + NN;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int DIV_STEPS = 64;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [3:0]         N_D  = 4'(N);
  localparam logic [3:0]         M_D  = 4'(M);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    lkf_pkg::op_t op;
    logic         tr;
    addr_t        abase;
    addr_t        bbase;
    addr_t        cbase;
    logic [3:0]   n;
    logic [3:0]   k;
    logic [3:0]   m;
    logic         to_det;
    logic         fin;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic is_ew(input lkf_pkg::op_t op);
    return (op == lkf_pkg::OP_ADD) || (op == lkf_pkg::OP_SUB) ||
           (op == lkf_pkg::OP_IDSUB) || (op == lkf_pkg::OP_COPY);
  endfunction

  function automatic job_t mk(input lkf_pkg::op_t op, input logic tr, input int a,
                              input int b, input int c, input int n, input int k,
                              input int m, input logic to_det, input logic fin);
    job_t jb;
    jb.op = op; jb.tr = tr;
    jb.abase = ADDR_W'(a); jb.bbase = ADDR_W'(b); jb.cbase = ADDR_W'(c);
    jb.n = 4'(n); jb.k = 4'(k); jb.m = 4'(m);
    jb.to_det = to_det; jb.fin = fin;
    return jb;
  endfunction

  // job program: predict runs steps 0-4, update steps 0-12 with the inverse after 4
  function automatic job_t get_job(input logic upd, input logic [3:0] st);
    job_t jb;
    jb = mk(lkf_pkg::OP_COPY, 1'b0, OFS_X, OFS_X, OFS_X, 1, 1, 1, 1'b0, 1'b1);
    if (!upd) begin
      unique case (st)
        4'd0:    jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_F, OFS_X, OFS_FX, N, N, 1, 1'b0, 1'b0);
        4'd1:    jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_F, OFS_P, OFS_TA, N, N, N, 1'b0, 1'b0);
        4'd2:    jb = mk(lkf_pkg::OP_MAT, 1'b1, OFS_TA, OFS_F, OFS_TB, N, N, N, 1'b0, 1'b0);
        4'd3:    jb = mk(lkf_pkg::OP_ADD, 1'b0, OFS_TB, OFS_Q, OFS_P, N, 1, N, 1'b0, 1'b0);
        default: jb = mk(lkf_pkg::OP_COPY, 1'b0, OFS_FX, OFS_FX, OFS_X, N, 1, 1, 1'b0, 1'b1);
      endcase
    end else begin
      unique case (st)
        4'd0:  jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_H, OFS_X, OFS_HX, M, N, 1, 1'b0, 1'b0);
        4'd1:  jb = mk(lkf_pkg::OP_SUB, 1'b0, OFS_Z, OFS_HX, OFS_Y, M, 1, 1, 1'b0, 1'b0);
        4'd2:  jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_H, OFS_P, OFS_HP, M, N, N, 1'b0, 1'b0);
        4'd3:  jb = mk(lkf_pkg::OP_MAT, 1'b1, OFS_HP, OFS_H, OFS_S, M, N, M, 1'b0, 1'b0);
        4'd4:  jb = mk(lkf_pkg::OP_ADD, 1'b0, OFS_S, OFS_R, OFS_S, M, 1, M, 1'b1, 1'b0);
        4'd5:  jb = mk(lkf_pkg::OP_MAT, 1'b1, OFS_P, OFS_H, OFS_PHT, N, N, M, 1'b0, 1'b0);
        4'd6:  jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_PHT, OFS_SI, OFS_KG, N, M, M, 1'b0, 1'b0);
        4'd7:  jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_KG, OFS_Y, OFS_KY, N, M, 1, 1'b0, 1'b0);
        4'd8:  jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_KG, OFS_H, OFS_TA, N, M, N, 1'b0, 1'b0);
        4'd9:  jb = mk(lkf_pkg::OP_IDSUB, 1'b0, OFS_TA, OFS_TA, OFS_TA, N, 1, N, 1'b0, 1'b0);
        4'd10: jb = mk(lkf_pkg::OP_MAT, 1'b0, OFS_TA, OFS_P, OFS_TB, N, N, N, 1'b0, 1'b0);
        4'd11: jb = mk(lkf_pkg::OP_ADD, 1'b0, OFS_X, OFS_KY, OFS_X, N, 1, 1, 1'b0, 1'b0);
        default: jb = mk(lkf_pkg::OP_COPY, 1'b0, OFS_TB, OFS_TB, OFS_P, N, 1, N, 1'b0, 1'b1);
      endcase
    end
    return jb;
  endfunction

  lkf_pkg::state_t state, state_next;

  // sequencer registers
  logic              upd;
  logic [3:0]        step;
  logic [2:0]        cnt_i, cnt_j, cnt_t;
  logic [1:0]        cnt_e;
  logic [2:0]        idx;
  logic [DCNT_W-1:0] div_cnt;
  addr_t             clr_addr;
  logic signed [31:0] z_second;
  logic              status_r;

  // engine pipeline
  logic               v1, v2;
  lkf_pkg::tag_t      tag0, tag1, tag2;
  addr_t              caddr0, caddr1, caddr2;
  logic signed [63:0] prod, acc, acc_next, qr;
  logic signed [31:0] ew, ew_comb;
  logic signed [63:0] det;
  logic               issue;

  // divider
  logic [63:0] dnum, dden, rem, quo, rem_sh;
  logic        qneg;
  logic signed [63:0] adj_num;

  // memory
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_a, rd_b;
  addr_t              raddr_a, raddr_b, waddr;
  logic               we;
  logic signed [31:0] wdata;

  job_t  job;
  logic  t_end, j_end, i_end, ld_ok;
  addr_t ld_addr;

  assign job   = get_job(upd, step);
  assign t_end = ({1'b0, cnt_t} + 4'd1) == job.k;
  assign j_end = ({1'b0, cnt_j} + 4'd1) == job.m;
  assign i_end = ({1'b0, cnt_i} + 4'd1) == job.n;
  assign in_ready = (state == lkf_pkg::ST_IDLE);

  // load target decode with range check
  always_comb begin
    ld_ok   = 1'b0;
    ld_addr = '0;
    unique case (matrix_select)
      lkf_pkg::SEL_EST: begin
        ld_ok   = {1'b0, row_index} < N_D;
        ld_addr = ADDR_W'(OFS_X) + ADDR_W'(row_index);
      end
      lkf_pkg::SEL_COV, lkf_pkg::SEL_TRANS, lkf_pkg::SEL_PNOISE: begin
        ld_ok   = ({1'b0, row_index} < N_D) && ({1'b0, col_index} < N_D);
        ld_addr = ADDR_W'(row_index) * ADDR_W'(N) + ADDR_W'(col_index);
        if (matrix_select == lkf_pkg::SEL_COV) ld_addr = ld_addr + ADDR_W'(OFS_P);
        else if (matrix_select == lkf_pkg::SEL_TRANS) ld_addr = ld_addr + ADDR_W'(OFS_F);
        else ld_addr = ld_addr + ADDR_W'(OFS_Q);
      end
      lkf_pkg::SEL_MEAS: begin
        ld_ok   = ({1'b0, row_index} < M_D) && ({1'b0, col_index} < N_D);
        ld_addr = ADDR_W'(OFS_H) + ADDR_W'(row_index) * ADDR_W'(N) + ADDR_W'(col_index);
      end
      lkf_pkg::SEL_MNOISE: begin
        ld_ok   = ({1'b0, row_index} < M_D) && ({1'b0, col_index} < M_D);
        ld_addr = ADDR_W'(OFS_R) + ADDR_W'(row_index) * ADDR_W'(M) + ADDR_W'(col_index);
      end
      default: begin
        ld_ok   = 1'b0;
        ld_addr = '0;
      end
    endcase
  end

  // element ops at the data stage
  always_comb begin
    case (tag1.op)
      lkf_pkg::OP_ADD:   ew_comb = sat32(65'(rd_a) + 65'(rd_b));
      lkf_pkg::OP_SUB:   ew_comb = sat32(65'(rd_a) - 65'(rd_b));
      lkf_pkg::OP_IDSUB: ew_comb = sat32((tag1.diag ? 65'(ONE_Q) : 65'sd0) - 65'(rd_a));
      default:           ew_comb = rd_a;
    endcase
  end

  // round half up, then accumulate
  assign qr       = (prod + HALF) >>> FRAC_BITS;
  assign acc_next = (tag2.first ? 64'sd0 : acc) + (tag2.neg ? -qr : qr);

  // adjugate term times one, for the inverse of S
  always_comb begin
    if (M == 1) adj_num = 64'(ONE_Q) <<< FRAC_BITS;
    else if (cnt_e == 2'd1 || cnt_e == 2'd2) adj_num = (-64'(rd_a)) <<< FRAC_BITS;
    else adj_num = 64'(rd_a) <<< FRAC_BITS;
  end

  assign rem_sh = {rem[62:0], dnum[63]};

  // sequencer: next state, memory ports, issue
  always_comb begin
    state_next = state;
    raddr_a    = '0;
    raddr_b    = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    issue      = 1'b0;
    tag0       = '{op: job.op, first: 1'b1, last: 1'b1, neg: 1'b0, diag: cnt_i == cnt_j};
    caddr0     = job.cbase + ADDR_W'(cnt_i) * ADDR_W'(job.m) + ADDR_W'(cnt_j);
    unique case (state)
      lkf_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = lkf_pkg::ST_IDLE;
      end
      lkf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (func == lkf_pkg::FUNC_LOAD) begin
            we    = ld_ok;
            waddr = ld_addr;
            wdata = load_value;
          end else if (func == lkf_pkg::FUNC_PREDICT) begin
            state_next = lkf_pkg::ST_JOB;
          end else if (func == lkf_pkg::FUNC_UPDATE) begin
            we         = 1'b1;
            waddr      = ADDR_W'(OFS_Z);
            wdata      = meas_first;
            state_next = lkf_pkg::ST_ZWR;
          end
        end
      end
      lkf_pkg::ST_ZWR: begin
        we         = 1'b1;
        waddr      = ADDR_W'(OFS_Z + 1);
        wdata      = z_second;
        state_next = lkf_pkg::ST_JOB;
      end
      lkf_pkg::ST_JOB: begin
        issue = 1'b1;
        if (job.op == lkf_pkg::OP_MAT) begin
          raddr_a = job.abase + ADDR_W'(cnt_i) * ADDR_W'(job.k) + ADDR_W'(cnt_t);
          raddr_b = job.tr ?
                    job.bbase + ADDR_W'(cnt_j) * ADDR_W'(job.k) + ADDR_W'(cnt_t) :
                    job.bbase + ADDR_W'(cnt_t) * ADDR_W'(job.m) + ADDR_W'(cnt_j);
          tag0.first = (cnt_t == 3'd0);
          tag0.last  = t_end;
        end else begin
          raddr_a = job.abase + ADDR_W'(cnt_i) * ADDR_W'(job.m) + ADDR_W'(cnt_j);
          raddr_b = job.bbase + ADDR_W'(cnt_i) * ADDR_W'(job.m) + ADDR_W'(cnt_j);
        end
        if (t_end && j_end && i_end) state_next = lkf_pkg::ST_DRAIN;
      end
      lkf_pkg::ST_DRAIN: begin
        if (!v1 && !v2) begin
          if (job.to_det) state_next = lkf_pkg::ST_DET;
          else if (job.fin) state_next = lkf_pkg::ST_EMIT_RD;
          else state_next = lkf_pkg::ST_JOB;
        end
      end
      lkf_pkg::ST_DET: begin
        issue = 1'b1;
        if (M == 1) begin
          raddr_a    = ADDR_W'(OFS_S);
          tag0.op    = lkf_pkg::OP_DET1;
          state_next = lkf_pkg::ST_DET_WAIT;
        end else begin
          // det = s00*s11 - s01*s10
          tag0.op    = lkf_pkg::OP_DET;
          tag0.first = (cnt_t == 3'd0);
          tag0.last  = (cnt_t != 3'd0);
          tag0.neg   = (cnt_t != 3'd0);
          raddr_a    = (cnt_t == 3'd0) ? ADDR_W'(OFS_S) : ADDR_W'(OFS_S + 1);
          raddr_b    = (cnt_t == 3'd0) ? ADDR_W'(OFS_S + 3) : ADDR_W'(OFS_S + 2);
          if (cnt_t != 3'd0) state_next = lkf_pkg::ST_DET_WAIT;
        end
      end
      lkf_pkg::ST_DET_WAIT: begin
        if (!v1 && !v2) begin
          if (det == 64'sd0) state_next = lkf_pkg::ST_EMIT_RD;
          else state_next = lkf_pkg::ST_INV_RD;
        end
      end
      lkf_pkg::ST_INV_RD: begin
        if (cnt_e == 2'd0) raddr_a = ADDR_W'(OFS_S + MM - 1);
        else if (cnt_e == 2'd3) raddr_a = ADDR_W'(OFS_S);
        else raddr_a = ADDR_W'(OFS_S) + ADDR_W'(cnt_e);
        state_next = lkf_pkg::ST_INV_LD;
      end
      lkf_pkg::ST_INV_LD: state_next = lkf_pkg::ST_INV_DIV;
      lkf_pkg::ST_INV_DIV: begin
        if (div_cnt == DCNT_W'(DIV_STEPS - 1)) state_next = lkf_pkg::ST_INV_WR;
      end
      lkf_pkg::ST_INV_WR: begin
        we    = 1'b1;
        waddr = ADDR_W'(OFS_SI) + ADDR_W'(cnt_e);
        wdata = sat32(qneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
        if (cnt_e == 2'(MM - 1)) state_next = lkf_pkg::ST_JOB;
        else state_next = lkf_pkg::ST_INV_RD;
      end
      lkf_pkg::ST_EMIT_RD: begin
        raddr_a    = ADDR_W'(OFS_X) + ADDR_W'(idx);
        state_next = lkf_pkg::ST_EMIT_LD;
      end
      lkf_pkg::ST_EMIT_LD: state_next = lkf_pkg::ST_EMIT_WAIT;
      lkf_pkg::ST_EMIT_WAIT: begin
        if (out_ready) begin
          if (last_elem) state_next = lkf_pkg::ST_IDLE;
          else state_next = lkf_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = lkf_pkg::ST_IDLE;
    endcase
    // result write-back from the engine
    if (v2 && ((tag2.op == lkf_pkg::OP_MAT && tag2.last) || is_ew(tag2.op))) begin
      we    = 1'b1;
      waddr = caddr2;
      wdata = (tag2.op == lkf_pkg::OP_MAT) ? sat32(65'(acc_next)) : ew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lkf_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // scratch memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // counters and control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      step      <= '0;
      cnt_i     <= '0;
      cnt_j     <= '0;
      cnt_t     <= '0;
      cnt_e     <= '0;
      idx       <= '0;
      div_cnt   <= '0;
      upd       <= 1'b0;
      status_r  <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      unique case (state)
        lkf_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        lkf_pkg::ST_IDLE: begin
          step     <= '0;
          idx      <= '0;
          status_r <= 1'b0;
          upd      <= (func == lkf_pkg::FUNC_UPDATE);
        end
        lkf_pkg::ST_JOB: begin
          if (!t_end) cnt_t <= cnt_t + 1'b1;
          else begin
            cnt_t <= '0;
            if (!j_end) cnt_j <= cnt_j + 1'b1;
            else begin
              cnt_j <= '0;
              if (!i_end) cnt_i <= cnt_i + 1'b1;
              else cnt_i <= '0;
            end
          end
        end
        lkf_pkg::ST_DRAIN: begin
          if (!v1 && !v2 && !job.to_det && !job.fin) step <= step + 1'b1;
        end
        lkf_pkg::ST_DET: cnt_t <= (cnt_t == 3'd0 && M != 1) ? 3'd1 : 3'd0;
        lkf_pkg::ST_DET_WAIT: begin
          cnt_e <= '0;
          if (!v1 && !v2 && det == 64'sd0) status_r <= 1'b1;
        end
        lkf_pkg::ST_INV_LD: div_cnt <= '0;
        lkf_pkg::ST_INV_DIV: div_cnt <= div_cnt + 1'b1;
        lkf_pkg::ST_INV_WR: begin
          cnt_e <= cnt_e + 1'b1;
          if (cnt_e == 2'(MM - 1)) step <= step + 1'b1;
        end
        lkf_pkg::ST_EMIT_LD: out_valid <= 1'b1;
        lkf_pkg::ST_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            idx       <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == lkf_pkg::ST_IDLE) z_second <= (M == 1) ? 32'sd0 : meas_second;
    tag1   <= tag0;
    caddr1 <= caddr0;
    tag2   <= tag1;
    caddr2 <= caddr1;
    prod   <= 64'(rd_a) * 64'(rd_b);
    ew     <= ew_comb;
    if (v2 && (tag2.op == lkf_pkg::OP_MAT || tag2.op == lkf_pkg::OP_DET)) acc <= acc_next;
    if (v2 && tag2.op == lkf_pkg::OP_DET && tag2.last) det <= acc_next;
    if (v2 && tag2.op == lkf_pkg::OP_DET1) det <= 64'(ew);
    if (state == lkf_pkg::ST_INV_LD) begin
      dnum <= adj_num[63] ? 64'(-adj_num) : 64'(adj_num);
      dden <= det[63] ? 64'(-det) : 64'(det);
      qneg <= adj_num[63] ^ det[63];
      rem  <= '0;
      quo  <= '0;
    end else if (state == lkf_pkg::ST_INV_DIV) begin
      dnum <= {dnum[62:0], 1'b0};
      if (rem_sh >= dden) begin
        rem <= rem_sh - dden;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
    end
    if (state == lkf_pkg::ST_EMIT_LD) begin
      elem_value <= rd_a;
      elem_index <= idx;
      last_elem  <= (idx == 3'(N - 1));
      status     <= status_r;
    end
  end

  // a job only starts with the engine pipeline empty
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == lkf_pkg::ST_DRAIN && state_next != lkf_pkg::ST_DRAIN) |-> (!v1 && !v2))
    else $error("job advanced with engine busy");

  // restoring divider keeps remainder below divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == lkf_pkg::ST_INV_DIV) |-> (rem < dden))
    else $error("divider remainder out of range");

  // the final beat carries the last element index
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_elem) |-> (elem_index == 3'(N - 1)))
    else $error("last beat index mismatch");

  // writes stay in the memory map
  a_waddr: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr < ADDR_W'(DEPTH)))
    else $error("scratch write beyond memory");

endmodule

>>> tb/linear_kalman_filter_test.sv
module linear_kalman_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = lkf_pkg::STATE_DIM_DEF;
  localparam int NM = lkf_pkg::MEAS_DIM_DEF;
  localparam int FB = lkf_pkg::FRAC_BITS_DEF;
  localparam longint ONE_Q = longint'(1) << FB;

  // codes the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [2:0] SEL_BAD_LO  = 3'd6;
  localparam logic [2:0] SEL_BAD_HI  = 3'd7;

  typedef int mat_t [16];

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] val;
    logic        last;
    logic        st;
  } elem_t;

  // Filter state mirror plus queue of expected estimate beats.
  class filter_scoreboard;
    mat_t  est, cov, trn, hmat, rnoise, qnoise;
    elem_t pending [$];
    int    errors;

    function void clear();
      foreach (est[i]) begin
        est[i] = 0; cov[i] = 0; trn[i] = 0;
        hmat[i] = 0; rnoise[i] = 0; qnoise[i] = 0;
      end
      pending.delete();
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // exact product, round half up to FB fraction bits
    function longint qmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) << (FB - 1));
      return p >>> FB;
    endfunction

    function void matmul(input mat_t a, input mat_t b, output mat_t c,
                         input int n, input int k, input int m, input bit tr);
      longint acc;
      foreach (c[i]) c[i] = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < m; j++) begin
          acc = 0;
          for (int t = 0; t < k; t++)
            acc += qmul(a[i*k+t], tr ? b[j*k+t] : b[t*m+j]);
          c[i*m+j] = sat32(acc);
        end
    endfunction

    function void do_load(logic [2:0] sel, int r, int c, int v);
      case (sel)
        lkf_pkg::SEL_EST:    if (r < NS) est[r] = v;
        lkf_pkg::SEL_COV:    if (r < NS && c < NS) cov[r*NS+c] = v;
        lkf_pkg::SEL_TRANS:  if (r < NS && c < NS) trn[r*NS+c] = v;
        lkf_pkg::SEL_MEAS:   if (r < NM && c < NS) hmat[r*NS+c] = v;
        lkf_pkg::SEL_MNOISE: if (r < NM && c < NM) rnoise[r*NM+c] = v;
        lkf_pkg::SEL_PNOISE: if (r < NS && c < NS) qnoise[r*NS+c] = v;
        default: ;
      endcase
    endfunction

    function void do_predict();
      mat_t fx, fp, fpf;
      matmul(trn, est, fx, NS, NS, 1, 0);
      matmul(trn, cov, fp, NS, NS, NS, 0);
      matmul(fp, trn, fpf, NS, NS, NS, 1);
      for (int i = 0; i < NS; i++) est[i] = fx[i];
      for (int i = 0; i < NS*NS; i++)
        cov[i] = sat32(longint'(fpf[i]) + longint'(qnoise[i]));
    endfunction

    // returns 0 when the innovation covariance is singular
    function bit do_update(int z0, int z1);
      mat_t hx, y, hp, s, si, pht, kg, ky, kh, ikh, np;
      longint det;
      longint adj [4];
      int z [2];
      z[0] = z0; z[1] = z1;
      foreach (y[i]) y[i] = 0;
      matmul(hmat, est, hx, NM, NS, 1, 0);
      for (int i = 0; i < NM; i++) y[i] = sat32(longint'(z[i]) - longint'(hx[i]));
      matmul(hmat, cov, hp, NM, NS, NS, 0);
      matmul(hp, hmat, s, NM, NS, NM, 1);
      for (int i = 0; i < NM*NM; i++) s[i] = sat32(longint'(s[i]) + longint'(rnoise[i]));
      if (NM == 1) begin
        det = s[0];
        adj[0] = ONE_Q;
      end else begin
        det = qmul(s[0], s[3]) - qmul(s[1], s[2]);
        adj[0] = s[3];
        adj[1] = -longint'(s[1]);
        adj[2] = -longint'(s[2]);
        adj[3] = s[0];
      end
      if (det == 0) return 0;
      foreach (si[i]) si[i] = 0;
      for (int i = 0; i < NM*NM; i++) si[i] = sat32((adj[i] * ONE_Q) / det);
      matmul(cov, hmat, pht, NS, NS, NM, 1);
      matmul(pht, si, kg, NS, NM, NM, 0);
      matmul(kg, y, ky, NS, NM, 1, 0);
      matmul(kg, hmat, kh, NS, NM, NS, 0);
      foreach (ikh[i]) ikh[i] = 0;
      for (int i = 0; i < NS; i++)
        for (int j = 0; j < NS; j++)
          ikh[i*NS+j] = sat32((i == j ? ONE_Q : 0) - longint'(kh[i*NS+j]));
      matmul(ikh, cov, np, NS, NS, NS, 0);
      for (int i = 0; i < NS; i++) est[i] = sat32(longint'(est[i]) + longint'(ky[i]));
      for (int i = 0; i < NS*NS; i++) cov[i] = np[i];
      return 1;
    endfunction

    function void queue_estimate(bit st);
      elem_t e;
      for (int i = 0; i < NS; i++) begin
        e.idx = i[2:0]; e.val = est[i]; e.last = (i == NS-1); e.st = st;
        pending.push_back(e);
      end
    endfunction

    // accepted input beat
    function void note_input(logic [1:0] f, logic [2:0] sel, logic [2:0] r,
                             logic [2:0] c, int v, int z0, int z1);
      case (f)
        lkf_pkg::FUNC_LOAD:    do_load(sel, r, c, v);
        lkf_pkg::FUNC_PREDICT: begin do_predict(); queue_estimate(0); end
        lkf_pkg::FUNC_UPDATE:  queue_estimate(!do_update(z0, (NM == 1) ? 0 : z1));
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // accepted output beat
    task check_result(logic [2:0] idx, logic [31:0] val, logic last, logic st);
      elem_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat idx=%0d val=%h", idx, val));
        return;
      end
      e = pending.pop_front();
      if (idx !== e.idx) report($sformatf("elem_index %0d, want %0d", idx, e.idx));
      if (val !== e.val) report($sformatf("elem_value[%0d] %h, want %h", e.idx, val, e.val));
      if (last !== e.last) report($sformatf("last_elem[%0d] %b, want %b", e.idx, last, e.last));
      if (st !== e.st) report($sformatf("status[%0d] %b, want %b", e.idx, st, e.st));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] func = lkf_pkg::FUNC_LOAD;
  logic [2:0] matrix_select = lkf_pkg::SEL_EST, row_index = 3'd0, col_index = 3'd0;
  logic signed [31:0] load_value = 0, meas_first = 0, meas_second = 0;
  logic out_valid, out_ready = 0;
  logic [2:0] elem_index;
  logic signed [31:0] elem_value;
  logic last_elem, status;

  filter_scoreboard sb = new();
  bit quiet = 0;  // phases with no idling on either side
  int sent = 0;   // accepted input beats

  linear_kalman_filter dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // gaps: mostly short, now and then long
  function int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // output side: monitor at the rising edge, random backpressure at the falling
  always @(posedge clk)
    if (!rst && out_valid && out_ready)
      sb.check_result(elem_index, elem_value, last_elem, status);

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 0;
        hold--;
      end else begin
        out_ready = 1;
        hold = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // one beat; called at a falling edge, returns at a falling edge after acceptance and any random gap
  task send_beat(logic [1:0] f, logic [2:0] sel, logic [2:0] r, logic [2:0] c,
                 int v, int z0, int z1);
    func = f; matrix_select = sel; row_index = r; col_index = c;
    load_value = v; meas_first = z0; meas_second = z1;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, sel, r, c, v, z0, z1);
    sent++;
    @(negedge clk);
    repeat (gap_len()) begin
      in_valid = 0;
      @(negedge clk);
    end
  endtask

  task load_elem(logic [2:0] sel, int r, int c, int v);
    send_beat(lkf_pkg::FUNC_LOAD, sel, r[2:0], c[2:0], v, $urandom, $urandom);
  endtask

  // small Q16.16 value in about [-2, 2)
  function int small_q();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  // sane system: near-identity F, H with unit diagonal, non-negative noise
  task setup_system();
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) begin
        load_elem(lkf_pkg::SEL_TRANS, i, j, (i == j) ? 65536 + (small_q() >>> 4)
                                                     : (small_q() >>> 3));
        if ($urandom_range(0, 2) == 0)
          load_elem(lkf_pkg::SEL_COV, i, j, (i == j) ? $urandom_range(65536, 327680) : 0);
        if (i == j) load_elem(lkf_pkg::SEL_PNOISE, i, j, $urandom_range(0, 16384));
      end
    for (int i = 0; i < NM; i++)
      for (int j = 0; j < NS; j++)
        load_elem(lkf_pkg::SEL_MEAS, i, j, (i == j) ? 65536 : (small_q() >>> 2));
    for (int i = 0; i < NM; i++)
      for (int j = 0; j < NM; j++)
        load_elem(lkf_pkg::SEL_MNOISE, i, j, (i == j) ? $urandom_range(8192, 131072) : 0);
  endtask

  initial begin
    int k;
    sb.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: everything zero, so S is singular
    quiet = 1;
    send_beat(lkf_pkg::FUNC_UPDATE, lkf_pkg::SEL_EST, 3'd0, 3'd0, 0,
              32'sh7fffffff, 32'sh80000000);
    send_beat(lkf_pkg::FUNC_PREDICT, lkf_pkg::SEL_EST, 3'd0, 3'd0, 0, 0, 0);
    // extremes into every store, plus out-of-range rows/cols and bad selects
    load_elem(lkf_pkg::SEL_EST, 0, 7, 32'sh7fffffff);
    load_elem(lkf_pkg::SEL_EST, 3, 0, 32'sh80000000);
    load_elem(lkf_pkg::SEL_EST, 7, 0, 32'sh12345678);
    load_elem(lkf_pkg::SEL_COV, 0, 0, 32'sh7fffffff);
    load_elem(lkf_pkg::SEL_TRANS, 0, 0, 32'sh80000000);
    load_elem(lkf_pkg::SEL_TRANS, 3, 3, 32'sh7fffffff);
    load_elem(lkf_pkg::SEL_MEAS, 2, 0, 32'sh55555555);
    load_elem(lkf_pkg::SEL_MNOISE, 1, 2, 32'shaaaaaaaa);
    load_elem(lkf_pkg::SEL_PNOISE, 3, 7, 32'sh0000ffff);
    load_elem(SEL_BAD_LO, 0, 0, 32'sh7fffffff);
    load_elem(SEL_BAD_HI, 1, 1, 32'sh80000000);
    send_beat(FUNC_UNUSED, lkf_pkg::SEL_EST, 3'd0, 3'd0, 32'shffffffff, 1, 1);
    send_beat(lkf_pkg::FUNC_PREDICT, lkf_pkg::SEL_EST, 3'd0, 3'd0, 0, 0, 0);  // saturates
    // identity system, non-singular update with extreme measurements
    for (int i = 0; i < NS; i++) begin
      load_elem(lkf_pkg::SEL_TRANS, i, i, 65536);
      load_elem(lkf_pkg::SEL_COV, i, i, 65536);
    end
    load_elem(lkf_pkg::SEL_MEAS, 0, 0, 65536);
    load_elem(lkf_pkg::SEL_MEAS, 1, 1, 65536);
    load_elem(lkf_pkg::SEL_MNOISE, 0, 0, 65536);
    load_elem(lkf_pkg::SEL_MNOISE, 1, 1, 65536);
    send_beat(lkf_pkg::FUNC_UPDATE, lkf_pkg::SEL_EST, 3'd0, 3'd0, 0,
              32'sh7fffffff, 32'sh80000000);
    send_beat(lkf_pkg::FUNC_PREDICT, lkf_pkg::SEL_EST, 3'd0, 3'd0, 0, 0, 0);

    // random: mostly filter cycles on a sane system, some noise
    while (sent < 170) begin
      quiet = ($urandom_range(0, 5) == 0);
      k = $urandom_range(0, 9);
      if (k == 0) begin
        setup_system();
      end else if (k <= 5) begin
        send_beat(($urandom_range(0, 1) != 0) ? lkf_pkg::FUNC_UPDATE : lkf_pkg::FUNC_PREDICT,
                  3'($urandom), 3'($urandom), 3'($urandom), $urandom,
                  small_q() <<< $urandom_range(0, 2), small_q() <<< $urandom_range(0, 2));
      end else if (k <= 7) begin
        load_elem(3'($urandom_range(0, 5)), $urandom_range(0, NS-1),
                  $urandom_range(0, NS-1), small_q());
      end else if (k == 8) begin
        // full-width noise: any field, any value
        send_beat(2'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                  $urandom, $urandom, $urandom);
      end else begin
        send_beat(lkf_pkg::FUNC_UPDATE, lkf_pkg::SEL_EST, 3'd0, 3'd0, 0,
                  $urandom, $urandom);
      end
    end
    in_valid = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** linear_kalman_filter: PASSED **");
    end else begin
      $display("** linear_kalman_filter: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** linear_kalman_filter: FAILED **");
    $finish;
  end

endmodule

>>> linear_kalman_filter.f
rtl/lkf_pkg.sv
rtl/linear_kalman_filter.sv
tb/linear_kalman_filter_test.sv
